[src/lsntc_pkg.sv]
`default_nettype none

package lsntc_pkg;

    localparam int SensorWidth = 13;
    localparam int CountWidth  = 16;
    localparam int LimitWidth  = 8;
    localparam int CfgIndexWidth = 3;

    localparam logic [SensorWidth-1:0] HighFloorReset   = 13'd2867;
    localparam logic [SensorWidth-1:0] HighCeilingReset = 13'd4096;
    localparam logic [SensorWidth-1:0] LowFloorReset    = 13'd0;
    localparam logic [SensorWidth-1:0] LowCeilingReset  = 13'd1638;
    localparam logic [LimitWidth-1:0]  RunMinimumReset  = 8'd7;
    localparam logic [LimitWidth-1:0]  LeftGapReset     = 8'd2;
    localparam logic [LimitWidth-1:0]  RightGapReset    = 8'd3;

    localparam logic [CountWidth-1:0] CountMax = '1;

    typedef enum logic [2:0] {
        PH_NODE      = 3'd0,
        PH_SKIP_L    = 3'd1,
        PH_SKIP_R    = 3'd2,
        PH_LEFT      = 3'd3,
        PH_LEFT_GAP  = 3'd4,
        PH_RIGHT     = 3'd5,
        PH_RIGHT_GAP = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        CLS_NODE  = 2'd0,
        CLS_LEFT  = 2'd1,
        CLS_RIGHT = 2'd2,
        CLS_OTHER = 2'd3
    } class_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_HIGH_FLOOR      = 3'd0,
        CFG_HIGH_CEILING    = 3'd1,
        CFG_LOW_FLOOR       = 3'd2,
        CFG_LOW_CEILING     = 3'd3,
        CFG_RUN_MINIMUM     = 3'd4,
        CFG_LEFT_GAP_LIMIT  = 3'd5,
        CFG_RIGHT_GAP_LIMIT = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [SensorWidth-1:0] sensor_a;
        logic [SensorWidth-1:0] sensor_b;
        logic [SensorWidth-1:0] sensor_c;
        logic [SensorWidth-1:0] sensor_d;
    } sample_t;

    typedef struct packed {
        logic [CountWidth-1:0] node_total;
        logic [CountWidth-1:0] turn_total;
        logic [CountWidth-1:0] left_total;
        logic [CountWidth-1:0] right_total;
        logic [1:0]            heading;
    } result_t;

    function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
        return (v == CountMax) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

[src/line_sensor_node_turn_counter.sv]
// Node and turn counter for a four-sensor line follower.
//
// Sample channel: sample_valid / sample_stall carry one beat of four
// 13-bit reflectance readings, leftmost first. A beat is taken at a rising
// edge with sample_valid high and sample_stall low.
// Result channel: result_valid / result_stall carry one beat per sample:
// node, turn, left and right totals (saturating at 65535) and the heading.
// The result of a sample is registered and valid in the cycle after it is
// taken. One sample per cycle while no result is stalled; the whole phase
// cascade is evaluated in one pass from the phase and run registers.
// When the receiver stalls, the result register holds its beat and
// sample_stall rises in the same cycle, so no sample is taken until the
// waiting result leaves.
// Config port: cfg_wr_en writes cfg_data into register cfg_index at the
// clock edge; index 7 is ignored. Write only while idle.
// Reset: all counts, runs and the heading clear, the phase returns to the
// node run, and the band bounds and limits take their default values.
`default_nettype none

module line_sensor_node_turn_counter (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      sample_valid,
    output      logic                                      sample_stall,
    input  wire lsntc_pkg::sample_t                        sample,
    output      logic                                      result_valid,
    input  wire logic                                      result_stall,
    output      lsntc_pkg::result_t                        result,
    input  wire logic                                      cfg_wr_en,
    input  wire logic [lsntc_pkg::CfgIndexWidth-1:0]       cfg_index,
    input  wire logic [lsntc_pkg::SensorWidth-1:0]         cfg_data
);

    localparam int SW = lsntc_pkg::SensorWidth;
    localparam int CW = lsntc_pkg::CountWidth;
    localparam int LW = lsntc_pkg::LimitWidth;

    logic [SW-1:0] high_floor_reg, high_ceiling_reg, low_floor_reg, low_ceiling_reg;
    logic [LW-1:0] run_minimum_reg, left_gap_limit_reg, right_gap_limit_reg;

    lsntc_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0] pattern_run_reg, pattern_run_next;
    logic [CW-1:0] gap_run_reg, gap_run_next;
    logic [CW-1:0] nodes_reg, nodes_next;
    logic [CW-1:0] lefts_reg, lefts_next;
    logic [CW-1:0] rights_reg, rights_next;
    logic [1:0]    balance_reg, balance_next;

    logic               result_valid_reg;
    lsntc_pkg::result_t result_reg, result_next;

    lsntc_pkg::class_t  sample_class;
    logic               accept;
    logic               done;
    logic [CW:0]        turn_sum;
    logic [CW-1:0]      run_min_wide;
    logic               a_high, b_high, c_high, d_high, a_low, d_low;

    assign sample_stall = result_valid_reg && result_stall;
    assign accept       = sample_valid && !sample_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign run_min_wide = {{(CW-LW){1'b0}}, run_minimum_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_floor_reg      <= lsntc_pkg::HighFloorReset;
            high_ceiling_reg    <= lsntc_pkg::HighCeilingReset;
            low_floor_reg       <= lsntc_pkg::LowFloorReset;
            low_ceiling_reg     <= lsntc_pkg::LowCeilingReset;
            run_minimum_reg     <= lsntc_pkg::RunMinimumReset;
            left_gap_limit_reg  <= lsntc_pkg::LeftGapReset;
            right_gap_limit_reg <= lsntc_pkg::RightGapReset;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lsntc_pkg::CFG_HIGH_FLOOR:      high_floor_reg      <= cfg_data;
                lsntc_pkg::CFG_HIGH_CEILING:    high_ceiling_reg    <= cfg_data;
                lsntc_pkg::CFG_LOW_FLOOR:       low_floor_reg       <= cfg_data;
                lsntc_pkg::CFG_LOW_CEILING:     low_ceiling_reg     <= cfg_data;
                lsntc_pkg::CFG_RUN_MINIMUM:     run_minimum_reg     <= cfg_data[LW-1:0];
                lsntc_pkg::CFG_LEFT_GAP_LIMIT:  left_gap_limit_reg  <= cfg_data[LW-1:0];
                lsntc_pkg::CFG_RIGHT_GAP_LIMIT: right_gap_limit_reg <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        a_high = (sample.sensor_a > high_floor_reg) && (sample.sensor_a < high_ceiling_reg);
        b_high = (sample.sensor_b > high_floor_reg) && (sample.sensor_b < high_ceiling_reg);
        c_high = (sample.sensor_c > high_floor_reg) && (sample.sensor_c < high_ceiling_reg);
        d_high = (sample.sensor_d > high_floor_reg) && (sample.sensor_d < high_ceiling_reg);
        a_low  = (sample.sensor_a > low_floor_reg) && (sample.sensor_a < low_ceiling_reg);
        d_low  = (sample.sensor_d > low_floor_reg) && (sample.sensor_d < low_ceiling_reg);
        if (b_high && c_high && a_high && d_high)
            sample_class = lsntc_pkg::CLS_NODE;
        else if (b_high && c_high && a_high && d_low)
            sample_class = lsntc_pkg::CLS_LEFT;
        else if (b_high && c_high && a_low && d_high)
            sample_class = lsntc_pkg::CLS_RIGHT;
        else
            sample_class = lsntc_pkg::CLS_OTHER;
    end

    // Phases only move forward within one sample, so walk them in order.
    always_comb
    begin
        phase_next       = phase_reg;
        pattern_run_next = pattern_run_reg;
        gap_run_next     = gap_run_reg;
        nodes_next       = nodes_reg;
        lefts_next       = lefts_reg;
        rights_next      = rights_reg;
        balance_next     = balance_reg;
        done             = 1'b0;

        if (phase_reg > lsntc_pkg::PH_RIGHT_GAP)
            phase_next = lsntc_pkg::PH_NODE;

        if (phase_next == lsntc_pkg::PH_NODE)
        begin
            if (sample_class == lsntc_pkg::CLS_NODE)
            begin
                pattern_run_next = lsntc_pkg::sat_inc(pattern_run_next);
                done = 1'b1;
            end
            else
            begin
                if (pattern_run_next > run_min_wide)
                begin
                    nodes_next = lsntc_pkg::sat_inc(nodes_next);
                    phase_next = lsntc_pkg::PH_SKIP_L;
                end
                else
                    phase_next = lsntc_pkg::PH_LEFT;
                pattern_run_next = '0;
            end
        end

        if (!done && phase_next == lsntc_pkg::PH_SKIP_L)
        begin
            if (sample_class == lsntc_pkg::CLS_LEFT)
                done = 1'b1;
            else
                phase_next = lsntc_pkg::PH_SKIP_R;
        end

        if (!done && phase_next == lsntc_pkg::PH_SKIP_R)
        begin
            if (sample_class == lsntc_pkg::CLS_RIGHT)
                done = 1'b1;
            else
                phase_next = lsntc_pkg::PH_LEFT;
        end

        if (!done && phase_next == lsntc_pkg::PH_LEFT)
        begin
            if (sample_class == lsntc_pkg::CLS_LEFT)
            begin
                pattern_run_next = lsntc_pkg::sat_inc(pattern_run_next);
                done = 1'b1;
            end
            else
                phase_next = lsntc_pkg::PH_LEFT_GAP;
        end

        if (!done && phase_next == lsntc_pkg::PH_LEFT_GAP)
        begin
            if (sample_class == lsntc_pkg::CLS_NODE)
            begin
                gap_run_next = lsntc_pkg::sat_inc(gap_run_next);
                done = 1'b1;
            end
            else
            begin
                if (pattern_run_next > run_min_wide
                    && gap_run_next < {{(CW-LW){1'b0}}, left_gap_limit_reg})
                begin
                    lefts_next   = lsntc_pkg::sat_inc(lefts_next);
                    balance_next = balance_next + 2'd1;
                end
                else if (gap_run_next > run_min_wide)
                    nodes_next = lsntc_pkg::sat_inc(nodes_next);
                pattern_run_next = '0;
                gap_run_next     = '0;
                phase_next       = lsntc_pkg::PH_RIGHT;
            end
        end

        if (!done && phase_next == lsntc_pkg::PH_RIGHT)
        begin
            if (sample_class == lsntc_pkg::CLS_RIGHT)
            begin
                pattern_run_next = lsntc_pkg::sat_inc(pattern_run_next);
                done = 1'b1;
            end
            else
                phase_next = lsntc_pkg::PH_RIGHT_GAP;
        end

        // Drop the sample that ends the right gap.
        if (!done && phase_next == lsntc_pkg::PH_RIGHT_GAP)
        begin
            if (sample_class == lsntc_pkg::CLS_NODE)
                gap_run_next = lsntc_pkg::sat_inc(gap_run_next);
            else
            begin
                if (pattern_run_next > run_min_wide
                    && gap_run_next < {{(CW-LW){1'b0}}, right_gap_limit_reg})
                begin
                    rights_next  = lsntc_pkg::sat_inc(rights_next);
                    balance_next = balance_next + 2'd3;
                end
                else if (gap_run_next > run_min_wide)
                    nodes_next = lsntc_pkg::sat_inc(nodes_next);
                pattern_run_next = '0;
                gap_run_next     = '0;
                phase_next       = lsntc_pkg::PH_NODE;
            end
        end

        turn_sum = {1'b0, lefts_next} + {1'b0, rights_next};
        result_next.node_total  = nodes_next;
        result_next.turn_total  = turn_sum[CW] ? lsntc_pkg::CountMax : turn_sum[CW-1:0];
        result_next.left_total  = lefts_next;
        result_next.right_total = rights_next;
        result_next.heading     = balance_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lsntc_pkg::PH_NODE;
            pattern_run_reg  <= '0;
            gap_run_reg      <= '0;
            nodes_reg        <= '0;
            lefts_reg        <= '0;
            rights_reg       <= '0;
            balance_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                pattern_run_reg <= pattern_run_next;
                gap_run_reg     <= gap_run_next;
                nodes_reg       <= nodes_next;
                lefts_reg       <= lefts_next;
                rights_reg      <= rights_next;
                balance_reg     <= balance_next;
            end
            if (accept)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("result beat missing after sample beat");

    a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(nodes_reg) && $stable(lefts_reg) && $stable(rights_reg))
        else $error("count changed without a sample beat");

    a_heading_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (lefts_reg != lsntc_pkg::CountMax && rights_reg != lsntc_pkg::CountMax)
        |-> balance_reg == 2'(lefts_reg - rights_reg))
        else $error("heading disagrees with turn counts");

    a_turn_total: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.turn_total >= result.left_total
                      && result.turn_total >= result.right_total)
        else $error("turn total below a turn count");

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    typedef logic [lsntc_pkg::SensorWidth-1:0] sensor_t;

    localparam logic [lsntc_pkg::CfgIndexWidth-1:0] CfgUnused = 3'd7;
    localparam int StallLimit = 2000;

    logic clk;
    logic rst_n;

    logic sample_valid = 1'b0;
    logic sample_stall;
    lsntc_pkg::sample_t sample_beat = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    lsntc_pkg::result_t result_beat;
    logic cfg_wr_en;
    logic [lsntc_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [lsntc_pkg::SensorWidth-1:0] cfg_data;

    lsntc_pkg::sample_t pending_samples[$];
    lsntc_pkg::result_t expected_totals[$];
    lsntc_pkg::result_t want_totals;
    int queued_items = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit tx_pause = 1'b0;
    bit rx_hold = 1'b0;
    bit sample_taken;

    // band bounds and limits as last written
    logic [lsntc_pkg::SensorWidth-1:0] high_lo, high_hi, low_lo, low_hi;
    logic [lsntc_pkg::LimitWidth-1:0] run_min, left_gap_max, right_gap_max;

    lsntc_pkg::phase_t walk_phase;
    logic [lsntc_pkg::CountWidth-1:0] pattern_len, gap_len;
    logic [lsntc_pkg::CountWidth-1:0] node_cnt, left_cnt, right_cnt;
    logic [1:0] balance;

    line_sensor_node_turn_counter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_high(logic [lsntc_pkg::SensorWidth-1:0] x);
        return x > high_lo && x < high_hi;
    endfunction

    function automatic bit is_low(logic [lsntc_pkg::SensorWidth-1:0] x);
        return x > low_lo && x < low_hi;
    endfunction

    function automatic logic [lsntc_pkg::CountWidth-1:0] bump(
        logic [lsntc_pkg::CountWidth-1:0] v);
        return (v == lsntc_pkg::CountMax) ? v : v + 16'd1;
    endfunction

    function automatic void settle_turn(logic [lsntc_pkg::LimitWidth-1:0] gap_max,
                                        bit is_left);
        if (pattern_len > run_min && gap_len < gap_max)
        begin
            if (is_left)
            begin
                left_cnt = bump(left_cnt);
                balance = balance + 2'd1;
            end
            else
            begin
                right_cnt = bump(right_cnt);
                balance = balance - 2'd1;
            end
        end
        else if (gap_len > run_min)
        begin
            node_cnt = bump(node_cnt);
        end
        pattern_len = '0;
        gap_len = '0;
    endfunction

    function automatic lsntc_pkg::result_t count_sample(lsntc_pkg::sample_t s);
        lsntc_pkg::class_t cls;
        bit mid;
        bit done;
        logic [lsntc_pkg::CountWidth:0] turns;
        lsntc_pkg::result_t r;
        mid = is_high(s.sensor_b) && is_high(s.sensor_c);
        if (mid && is_high(s.sensor_a) && is_high(s.sensor_d))
            cls = lsntc_pkg::CLS_NODE;
        else if (mid && is_high(s.sensor_a) && is_low(s.sensor_d))
            cls = lsntc_pkg::CLS_LEFT;
        else if (mid && is_low(s.sensor_a) && is_high(s.sensor_d))
            cls = lsntc_pkg::CLS_RIGHT;
        else
            cls = lsntc_pkg::CLS_OTHER;
        done = 1'b0;
        for (int guard = 0; guard < 9 && !done; guard++)
        begin
            case (walk_phase)
                lsntc_pkg::PH_NODE:
                begin
                    if (cls == lsntc_pkg::CLS_NODE)
                    begin
                        pattern_len = bump(pattern_len);
                        done = 1'b1;
                    end
                    else
                    begin
                        if (pattern_len > run_min)
                        begin
                            node_cnt = bump(node_cnt);
                            walk_phase = lsntc_pkg::PH_SKIP_L;
                        end
                        else
                        begin
                            walk_phase = lsntc_pkg::PH_LEFT;
                        end
                        pattern_len = '0;
                    end
                end
                lsntc_pkg::PH_SKIP_L:
                begin
                    if (cls == lsntc_pkg::CLS_LEFT) done = 1'b1;
                    else walk_phase = lsntc_pkg::PH_SKIP_R;
                end
                lsntc_pkg::PH_SKIP_R:
                begin
                    if (cls == lsntc_pkg::CLS_RIGHT) done = 1'b1;
                    else walk_phase = lsntc_pkg::PH_LEFT;
                end
                lsntc_pkg::PH_LEFT:
                begin
                    if (cls == lsntc_pkg::CLS_LEFT)
                    begin
                        pattern_len = bump(pattern_len);
                        done = 1'b1;
                    end
                    else
                    begin
                        walk_phase = lsntc_pkg::PH_LEFT_GAP;
                    end
                end
                lsntc_pkg::PH_LEFT_GAP:
                begin
                    if (cls == lsntc_pkg::CLS_NODE)
                    begin
                        gap_len = bump(gap_len);
                        done = 1'b1;
                    end
                    else
                    begin
                        settle_turn(left_gap_max, 1'b1);
                        walk_phase = lsntc_pkg::PH_RIGHT;
                    end
                end
                lsntc_pkg::PH_RIGHT:
                begin
                    if (cls == lsntc_pkg::CLS_RIGHT)
                    begin
                        pattern_len = bump(pattern_len);
                        done = 1'b1;
                    end
                    else
                    begin
                        walk_phase = lsntc_pkg::PH_RIGHT_GAP;
                    end
                end
                lsntc_pkg::PH_RIGHT_GAP:
                begin
                    if (cls == lsntc_pkg::CLS_NODE)
                    begin
                        gap_len = bump(gap_len);
                    end
                    else
                    begin
                        settle_turn(right_gap_max, 1'b0);
                        walk_phase = lsntc_pkg::PH_NODE;
                    end
                    done = 1'b1;
                end
                default: walk_phase = lsntc_pkg::PH_NODE;
            endcase
        end
        turns = {1'b0, left_cnt} + right_cnt;
        r.node_total = node_cnt;
        r.turn_total = turns[lsntc_pkg::CountWidth] ? lsntc_pkg::CountMax
                                                     : turns[lsntc_pkg::CountWidth-1:0];
        r.left_total = left_cnt;
        r.right_total = right_cnt;
        r.heading = balance;
        return r;
    endfunction

    function automatic sensor_t pick_between(sensor_t lo, sensor_t hi);
        int l;
        int h;
        l = lo;
        h = hi;
        if (h - l < 2)
            return sensor_t'($urandom_range(8191));
        case ($urandom_range(3))
            0: return sensor_t'(l + 1);
            1: return sensor_t'(h - 1);
            default: return sensor_t'($urandom_range(h - 1, l + 1));
        endcase
    endfunction

    function automatic sensor_t any_value();
        case ($urandom_range(5))
            0: return pick_between(high_lo, high_hi);
            1: return pick_between(low_lo, low_hi);
            2: return sensor_t'($urandom_range(4096));
            3: return sensor_t'($urandom_range(8191));
            4: return $urandom_range(1) ? high_lo : high_hi;
            default: return $urandom_range(1) ? low_lo : low_hi;
        endcase
    endfunction

    function automatic lsntc_pkg::sample_t make_sample(lsntc_pkg::class_t cls);
        lsntc_pkg::sample_t s;
        s.sensor_a = pick_between(high_lo, high_hi);
        s.sensor_b = pick_between(high_lo, high_hi);
        s.sensor_c = pick_between(high_lo, high_hi);
        s.sensor_d = pick_between(high_lo, high_hi);
        case (cls)
            lsntc_pkg::CLS_NODE: ;
            lsntc_pkg::CLS_LEFT: s.sensor_d = pick_between(low_lo, low_hi);
            lsntc_pkg::CLS_RIGHT: s.sensor_a = pick_between(low_lo, low_hi);
            default:
            begin
                s.sensor_a = any_value();
                s.sensor_b = any_value();
                s.sensor_c = any_value();
                s.sensor_d = any_value();
            end
        endcase
        return s;
    endfunction

    function automatic int near(int v);
        if (v > 16)
            return $urandom_range(6);
        return $urandom_range(v + 2, (v >= 2) ? v - 2 : 0);
    endfunction

    task automatic put(int a, int b, int c, int d);
        lsntc_pkg::sample_t s;
        s.sensor_a = sensor_t'(a);
        s.sensor_b = sensor_t'(b);
        s.sensor_c = sensor_t'(c);
        s.sensor_d = sensor_t'(d);
        pending_samples.push_back(s);
        queued_items++;
    endtask

    // clean runs of the other class are all-dark samples, which no band in use here admits
    task automatic push_run(lsntc_pkg::class_t cls, int n, bit noisy);
        lsntc_pkg::sample_t dark;
        dark = '0;
        repeat (n)
        begin
            if (noisy && $urandom_range(99) < 4)
                pending_samples.push_back(
                    make_sample(lsntc_pkg::class_t'($urandom_range(3))));
            else if (!noisy && cls == lsntc_pkg::CLS_OTHER)
                pending_samples.push_back(dark);
            else
                pending_samples.push_back(make_sample(cls));
            queued_items++;
        end
    endtask

    task automatic fill_random(int count);
        int stop;
        stop = queued_items + count;
        while (queued_items < stop)
        begin
            if ($urandom_range(9) < 8)
            begin
                push_run(lsntc_pkg::CLS_NODE, near(run_min), 1'b1);
                if ($urandom_range(1))
                begin
                    push_run(lsntc_pkg::CLS_LEFT, $urandom_range(2), 1'b1);
                    push_run(lsntc_pkg::CLS_RIGHT, $urandom_range(2), 1'b1);
                end
                push_run(lsntc_pkg::CLS_LEFT, near(run_min), 1'b1);
                push_run(lsntc_pkg::CLS_NODE,
                         $urandom_range(1) ? near(left_gap_max) : near(run_min), 1'b1);
                push_run(lsntc_pkg::CLS_RIGHT, near(run_min), 1'b1);
                push_run(lsntc_pkg::CLS_NODE,
                         $urandom_range(1) ? near(right_gap_max) : near(run_min), 1'b1);
                push_run(lsntc_pkg::CLS_OTHER, 1, 1'b1);
            end
            else
            begin
                push_run(lsntc_pkg::class_t'($urandom_range(3)), $urandom_range(5, 1), 1'b1);
            end
        end
    endtask

    task automatic write_reg(logic [lsntc_pkg::CfgIndexWidth-1:0] idx,
                             logic [lsntc_pkg::SensorWidth-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            lsntc_pkg::CFG_HIGH_FLOOR: high_lo = data;
            lsntc_pkg::CFG_HIGH_CEILING: high_hi = data;
            lsntc_pkg::CFG_LOW_FLOOR: low_lo = data;
            lsntc_pkg::CFG_LOW_CEILING: low_hi = data;
            lsntc_pkg::CFG_RUN_MINIMUM: run_min = data[lsntc_pkg::LimitWidth-1:0];
            lsntc_pkg::CFG_LEFT_GAP_LIMIT: left_gap_max = data[lsntc_pkg::LimitWidth-1:0];
            lsntc_pkg::CFG_RIGHT_GAP_LIMIT: right_gap_max = data[lsntc_pkg::LimitWidth-1:0];
            default: ;
        endcase
    endtask

    task automatic finish_writes();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || sample_valid || expected_totals.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    // driver: hold a stalled beat, advance on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_beat <= '0;
        end
        else
        begin
            sample_taken = sample_valid && !sample_stall;
            if (sample_taken)
                expected_totals.push_back(count_sample(sample_beat));
            if (!sample_valid || sample_taken)
            begin
                if (pending_samples.size() != 0 && !tx_pause
                    && $urandom_range(99) >= tx_idle_pct)
                begin
                    sample_valid <= 1'b1;
                    sample_beat <= pending_samples.pop_front();
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_totals.size() == 0)
                begin
                    report_mismatch("unexpected result beat", result_beat.node_total, 0);
                end
                else
                begin
                    want_totals = expected_totals.pop_front();
                    if (result_beat.node_total !== want_totals.node_total)
                        report_mismatch("node_total", result_beat.node_total,
                                        want_totals.node_total);
                    if (result_beat.turn_total !== want_totals.turn_total)
                        report_mismatch("turn_total", result_beat.turn_total,
                                        want_totals.turn_total);
                    if (result_beat.left_total !== want_totals.left_total)
                        report_mismatch("left_total", result_beat.left_total,
                                        want_totals.left_total);
                    if (result_beat.right_total !== want_totals.right_total)
                        report_mismatch("right_total", result_beat.right_total,
                                        want_totals.right_total);
                    if (result_beat.heading !== want_totals.heading)
                        report_mismatch("heading", result_beat.heading, want_totals.heading);
                end
            end
            result_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        high_lo = lsntc_pkg::HighFloorReset;
        high_hi = lsntc_pkg::HighCeilingReset;
        low_lo = lsntc_pkg::LowFloorReset;
        low_hi = lsntc_pkg::LowCeilingReset;
        run_min = lsntc_pkg::RunMinimumReset;
        left_gap_max = lsntc_pkg::LeftGapReset;
        right_gap_max = lsntc_pkg::RightGapReset;
        walk_phase = lsntc_pkg::PH_NODE;
        pattern_len = '0;
        gap_len = '0;
        node_cnt = '0;
        left_cnt = '0;
        right_cnt = '0;
        balance = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct <= 19;
        rx_idle_pct <= 58;

        write_reg(lsntc_pkg::CFG_RUN_MINIMUM, 13'd1);
        write_reg(CfgUnused, 13'h1abc);
        finish_writes();

        put(4095, 4095, 4095, 4095);
        put(2868, 2868, 2868, 2868);
        put(3000, 3000, 3000, 1);
        put(1637, 4095, 4095, 4095);
        put(3000, 3000, 3000, 1637);
        put(4000, 4000, 4000, 100);
        put(4095, 4095, 4095, 4095);
        put(1, 3000, 3000, 3000);
        put(500, 3500, 3500, 3500);
        put(3000, 3000, 3000, 3000);
        put(4096, 4096, 4096, 4096);
        put(2867, 2867, 2867, 2867);
        put(3000, 3000, 3000, 1638);
        put(3000, 3000, 3000, 0);
        put(8191, 8191, 8191, 8191);
        put(0, 0, 0, 0);
        put(3000, 3000, 3000, 800);
        put(3000, 3000, 3000, 800);
        put(3500, 3500, 3500, 3500);
        put(3500, 3500, 3500, 3500);
        put(3500, 3500, 3500, 3500);
        put(0, 0, 0, 0);
        wait_drained();

        write_reg(lsntc_pkg::CFG_RUN_MINIMUM, sensor_t'(lsntc_pkg::RunMinimumReset));
        finish_writes();
        fill_random(110);
        @(posedge clk) rx_hold <= 1'b1;
        repeat (200) @(posedge clk);
        rx_hold <= 1'b0;
        tx_pause <= 1'b1;
        do
            @(negedge clk);
        while (sample_valid || expected_totals.size() != 0);
        @(posedge clk) tx_pause <= 1'b0;
        fill_random(110);
        wait_drained();

        tx_idle_pct <= 58;
        rx_idle_pct <= 19;
        write_reg(lsntc_pkg::CFG_HIGH_FLOOR, 13'd3000);
        write_reg(lsntc_pkg::CFG_HIGH_CEILING, 13'd4000);
        write_reg(lsntc_pkg::CFG_LOW_FLOOR, 13'd100);
        write_reg(lsntc_pkg::CFG_LOW_CEILING, 13'd2000);
        write_reg(lsntc_pkg::CFG_RUN_MINIMUM, 13'h1f02);
        write_reg(lsntc_pkg::CFG_LEFT_GAP_LIMIT, 13'h1e04);
        write_reg(lsntc_pkg::CFG_RIGHT_GAP_LIMIT, 13'h0101);
        finish_writes();
        fill_random(130);
        wait_drained();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        write_reg(lsntc_pkg::CFG_HIGH_FLOOR, 13'd0);
        write_reg(lsntc_pkg::CFG_HIGH_CEILING, 13'd4096);
        write_reg(lsntc_pkg::CFG_LOW_FLOOR, 13'd4096);
        write_reg(lsntc_pkg::CFG_LOW_CEILING, 13'd8191);
        write_reg(lsntc_pkg::CFG_RUN_MINIMUM, 13'd255);
        write_reg(lsntc_pkg::CFG_LEFT_GAP_LIMIT, 13'd0);
        write_reg(lsntc_pkg::CFG_RIGHT_GAP_LIMIT, 13'd255);
        finish_writes();
        push_run(lsntc_pkg::CLS_NODE, 257, 1'b0);
        push_run(lsntc_pkg::CLS_OTHER, 1, 1'b0);
        push_run(lsntc_pkg::CLS_LEFT, 3, 1'b0);
        push_run(lsntc_pkg::CLS_NODE, 257, 1'b0);
        push_run(lsntc_pkg::CLS_OTHER, 2, 1'b0);
        fill_random(40);
        wait_drained();

        repeat (5) @(posedge clk);
        if (expected_totals.size() != 0)
            report_mismatch("results never arrived", 0, expected_totals.size());
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
